@@ rtl/core/ffra_pkg.sv @@
// ----------------------------------------------------------------------------
// First-fit range allocator package
// Shared widths, codes and the free-range table entry type.
// ----------------------------------------------------------------------------
package ffra_pkg;

  localparam int MAX_HEAPS  = 4;
  localparam int MAX_RANGES = 32;

  localparam int HEAP_W  = $clog2(MAX_HEAPS);
  localparam int HCNT_W  = $clog2(MAX_HEAPS + 1);
  localparam int IDX_W   = $clog2(MAX_RANGES);
  localparam int RCNT_W  = $clog2(MAX_RANGES + 1);
  localparam int MADDR_W = HEAP_W + IDX_W;
  localparam int MDEPTH  = MAX_HEAPS * MAX_RANGES;

  localparam int ADDR_W  = 40;
  localparam int LEN_W   = 41;
  localparam int STAT_W  = 43;
  localparam int LIVE_W  = 16;
  localparam int ALGN_W  = 17;

  localparam logic [ADDR_W-1:0] DEFAULT_HEAP_RESET = 40'd268435456;
  localparam logic [4:0]        ALIGN_LOG2_MAX     = 5'd16;

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_INIT  = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_IGNORED  = 3'd1;
  localparam logic [2:0] ST_NOT_INIT = 3'd2;
  localparam logic [2:0] ST_NO_HEAP  = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [LEN_W-1:0]  len;
  } range_entry_t;

  localparam int ENTRY_W = $bits(range_entry_t);

endpackage

@@ rtl/core/ffra_if.sv @@
// ----------------------------------------------------------------------------
// First-fit range allocator channel interfaces
// Request, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ffra_in_if
  import ffra_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic [ADDR_W-1:0] req_size;
  logic [4:0]        align_log2;
  logic [ADDR_W-1:0] free_offset;
  logic [1:0]        free_heap;
  logic              free_valid;

  modport source (output valid, cmd, req_size, align_log2, free_offset, free_heap,
                  free_valid, input ready);
  modport sink   (input valid, cmd, req_size, align_log2, free_offset, free_heap,
                  free_valid, output ready);
endinterface

interface ffra_out_if
  import ffra_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [2:0]        status;
  logic [ADDR_W-1:0] alloc_offset;
  logic [1:0]        alloc_heap;
  logic              alloc_valid;
  logic [STAT_W-1:0] total_allocated;
  logic [STAT_W-1:0] peak_allocated;
  logic [LIVE_W-1:0] allocation_count;
  logic [STAT_W-1:0] total_heap_size;
  logic [2:0]        heap_count;

  modport source (output valid, status, alloc_offset, alloc_heap, alloc_valid,
                  total_allocated, peak_allocated, allocation_count, total_heap_size,
                  heap_count, input ready);
  modport sink   (input valid, status, alloc_offset, alloc_heap, alloc_valid,
                  total_allocated, peak_allocated, allocation_count, total_heap_size,
                  heap_count, output ready);
endinterface

interface ffra_cfg_if
  import ffra_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

@@ rtl/core/ffra_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ffra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/first_fit_range_allocator_top.sv @@
// ----------------------------------------------------------------------------
// First-fit range allocator
// Free-range tables of all heaps live in one RAM; a sequencer scans, splits,
// merges and shifts entries one at a time through its single read port.
// ----------------------------------------------------------------------------
// Sequence: init and clear go from dispatch through the statistics state to the
// result register, and the next request is taken once the sequencer is idle again.
// Allocate checks each entry in turn, passes each heap and then opens a new heap or
// gives up; free scans the entries below the freed offset, decides the merge and does
// any lower merge; a shift reads and writes each moved entry in turn. A held result stalls.
// Reset clears all counters and heaps; the range RAM needs no clearing pass.
module first_fit_range_allocator_top
  import ffra_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  ffra_in_if.sink    in_if,
  ffra_out_if.source out_if,
  ffra_cfg_if.sink   cfg_if
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_ANEXT = 4'd2;
  localparam logic [3:0] S_ACHK  = 4'd3;
  localparam logic [3:0] S_FNEXT = 4'd4;
  localparam logic [3:0] S_FCHK  = 4'd5;
  localparam logic [3:0] S_FDEC  = 4'd6;
  localparam logic [3:0] S_FMRG  = 4'd7;
  localparam logic [3:0] S_SUR   = 4'd8;
  localparam logic [3:0] S_SUW   = 4'd9;
  localparam logic [3:0] S_SDR   = 4'd10;
  localparam logic [3:0] S_SDW   = 4'd11;
  localparam logic [3:0] S_STAT  = 4'd12;
  localparam logic [3:0] S_FIN   = 4'd13;

  logic [3:0]        state_r;
  logic [ADDR_W-1:0] dflt_r;

  logic [1:0]        cmd_r;
  logic [ADDR_W-1:0] size_r;
  logic [ALGN_W-1:0] mask_r;
  logic [LEN_W-1:0]  spa_r;
  logic [ADDR_W-1:0] foff_r;
  logic [1:0]        fheap_r;
  logic              fvalid_r;

  logic [HCNT_W-1:0] h_r;
  logic [RCNT_W-1:0] i_r;
  logic [RCNT_W-1:0] j_r;
  range_entry_t      prev_r;
  range_entry_t      next_r;
  logic              next_ok_r;
  logic              mp_r;
  logic              mn_r;
  logic [LEN_W-1:0]  sum_r;
  range_entry_t      ins_r;

  logic [RCNT_W-1:0] cnt_r [MAX_HEAPS];
  logic [HCNT_W-1:0] heaps_r;
  logic              init_r;
  logic [STAT_W-1:0] in_use_r;
  logic [STAT_W-1:0] peak_r;
  logic [LIVE_W-1:0] live_r;
  logic [STAT_W-1:0] hbt_r;

  logic [2:0]        st_r;
  logic              grant_r;
  logic              freed_r;
  logic [ADDR_W-1:0] goff_r;
  logic [HEAP_W-1:0] gheap_r;

  logic               we_r;
  logic [MADDR_W-1:0] waddr_r;
  range_entry_t       wdata_r;
  logic [MADDR_W-1:0] raddr;
  range_entry_t       rdata;
  logic [ENTRY_W-1:0] rdata_raw;

  logic              out_valid_r;
  logic [2:0]        o_status_r;
  logic [ADDR_W-1:0] o_off_r;
  logic [1:0]        o_heap_r;
  logic              o_avalid_r;
  logic [STAT_W-1:0] o_inuse_r;
  logic [STAT_W-1:0] o_peak_r;
  logic [LIVE_W-1:0] o_live_r;
  logic [STAT_W-1:0] o_hbt_r;
  logic [2:0]        o_heaps_r;

  logic [HEAP_W-1:0] hh;
  logic [RCNT_W-1:0] ncur;
  logic [4:0]        lg_clamp;
  logic              out_load;

  // Allocation fit check on the entry just read.
  logic [LEN_W-1:0]   al;
  logic [LEN_W-1:0]   pad;
  logic [LEN_W:0]     need;
  logic [LEN_W-1:0]   rem;
  logic [LEN_W:0]     rs;
  logic               fit;
  logic               keep_gap;
  logic               keep_rem;

  // Free merge checks.
  logic [LEN_W:0]     off_end;
  logic [LEN_W:0]     prev_end;
  logic [LEN_W:0]     sum_prev;
  logic [LEN_W:0]     sum_next;
  logic [LEN_W:0]     sum_both;
  logic [LEN_W-1:0]   hs;
  logic [STAT_W:0]    hbt_add_hs;
  logic [STAT_W:0]    hbt_add_dflt;
  logic [STAT_W:0]    inuse_add;
  logic [STAT_W-1:0]  peak_new;

  assign hh   = h_r[HEAP_W-1:0];
  assign ncur = cnt_r[hh];
  assign lg_clamp = (in_if.align_log2 > ALIGN_LOG2_MAX) ? ALIGN_LOG2_MAX : in_if.align_log2;
  assign out_load = (state_r == S_FIN) && (!out_valid_r || out_if.ready);

  always_comb begin
    al       = ({1'b0, rdata.start} + {{(LEN_W-ALGN_W){1'b0}}, mask_r})
               & ~{{(LEN_W-ALGN_W){1'b0}}, mask_r};
    pad      = al - {1'b0, rdata.start};
    need     = {1'b0, pad} + {2'b00, size_r};
    fit      = !al[LEN_W-1] && (need <= {1'b0, rdata.len});
    rem      = rdata.len - need[LEN_W-1:0];
    rs       = {1'b0, al} + {2'b00, size_r};
    keep_gap = (pad != '0);
    keep_rem = (rem != '0) && (rs[LEN_W:ADDR_W] == '0);

    off_end  = {2'b00, foff_r} + {2'b00, size_r};
    prev_end = {2'b00, prev_r.start} + {1'b0, prev_r.len};
    sum_prev = {1'b0, prev_r.len} + {2'b00, size_r};
    sum_next = {1'b0, next_r.len} + {2'b00, size_r};
    sum_both = {1'b0, sum_r} + {1'b0, next_r.len};

    hs           = ({1'b0, dflt_r} > spa_r) ? {1'b0, dflt_r} : spa_r;
    hbt_add_hs   = {1'b0, hbt_r} + {{(STAT_W-LEN_W+1){1'b0}}, hs};
    hbt_add_dflt = {{(STAT_W-ADDR_W+1){1'b0}}, dflt_r};
    inuse_add    = {1'b0, in_use_r} + {{(STAT_W-ADDR_W+1){1'b0}}, size_r};
    peak_new     = (in_use_r > peak_r) ? in_use_r : peak_r;
  end

  always_comb begin
    case (state_r)
      S_SUR:   raddr = {hh, IDX_W'(j_r - 1'b1)};
      S_SDR:   raddr = {hh, IDX_W'(j_r + 1'b1)};
      default: raddr = {hh, i_r[IDX_W-1:0]};
    endcase
  end

  ffra_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MDEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we_r),
    .waddr (waddr_r),
    .wdata (wdata_r),
    .raddr (raddr),
    .rdata (rdata_raw)
  );
  assign rdata = range_entry_t'(rdata_raw);

  assign cfg_if.ready = rst_n;
  assign in_if.ready  = rst_n && (state_r == S_IDLE);

  assign out_if.valid            = out_valid_r;
  assign out_if.status           = o_status_r;
  assign out_if.alloc_offset     = o_off_r;
  assign out_if.alloc_heap       = o_heap_r;
  assign out_if.alloc_valid      = o_avalid_r;
  assign out_if.total_allocated  = o_inuse_r;
  assign out_if.peak_allocated   = o_peak_r;
  assign out_if.allocation_count = o_live_r;
  assign out_if.total_heap_size  = o_hbt_r;
  assign out_if.heap_count       = o_heaps_r;

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      cmd_r    <= in_if.cmd;
      size_r   <= in_if.req_size;
      mask_r   <= ALGN_W'((18'd1 << lg_clamp) - 18'd1);
      spa_r    <= {1'b0, in_if.req_size} + LEN_W'(18'd1 << lg_clamp);
      foff_r   <= in_if.free_offset;
      fheap_r  <= in_if.free_heap;
      fvalid_r <= in_if.free_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dflt_r      <= DEFAULT_HEAP_RESET;
      heaps_r     <= '0;
      init_r      <= 1'b0;
      in_use_r    <= '0;
      peak_r      <= '0;
      live_r      <= '0;
      hbt_r       <= '0;
      we_r        <= 1'b0;
      out_valid_r <= 1'b0;
      grant_r     <= 1'b0;
      freed_r     <= 1'b0;
      for (int k = 0; k < MAX_HEAPS; k++) begin
        cnt_r[k] <= '0;
      end
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        dflt_r <= cfg_if.data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_if.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          we_r <= 1'b0;
          if (in_if.valid) begin
            state_r <= S_DISP;
          end
        end

        S_DISP: begin
          grant_r <= 1'b0;
          i_r     <= '0;
          case (cmd_r)
            CMD_ALLOC: begin
              we_r    <= 1'b0;
              freed_r <= 1'b0;
              h_r     <= '0;
              if (!init_r) begin
                st_r    <= ST_NOT_INIT;
                state_r <= S_STAT;
              end else if (size_r == '0) begin
                st_r    <= ST_IGNORED;
                state_r <= S_STAT;
              end else begin
                st_r    <= ST_OK;
                state_r <= S_ANEXT;
              end
            end
            CMD_FREE: begin
              we_r      <= 1'b0;
              h_r       <= HCNT_W'(fheap_r);
              next_ok_r <= 1'b0;
              if (!init_r) begin
                st_r    <= ST_NOT_INIT;
                freed_r <= 1'b0;
                state_r <= S_STAT;
              end else if (!fvalid_r || (HCNT_W'(fheap_r) >= heaps_r)) begin
                st_r    <= ST_IGNORED;
                freed_r <= 1'b0;
                state_r <= S_STAT;
              end else if (size_r == '0) begin
                st_r    <= ST_OK;
                freed_r <= 1'b1;
                state_r <= S_STAT;
              end else begin
                st_r    <= ST_OK;
                freed_r <= 1'b0;
                state_r <= S_FNEXT;
              end
            end
            CMD_INIT: begin
              for (int k = 1; k < MAX_HEAPS; k++) begin
                cnt_r[k] <= '0;
              end
              st_r          <= ST_OK;
              freed_r       <= 1'b0;
              init_r        <= 1'b1;
              heaps_r       <= HCNT_W'(1);
              in_use_r      <= '0;
              peak_r        <= '0;
              live_r        <= '0;
              hbt_r         <= hbt_add_dflt[STAT_W-1:0];
              cnt_r[0]      <= (dflt_r != '0) ? RCNT_W'(1) : '0;
              we_r          <= (dflt_r != '0);
              waddr_r       <= '0;
              wdata_r.start <= '0;
              wdata_r.len   <= {1'b0, dflt_r};
              state_r       <= S_STAT;
            end
            default: begin
              for (int k = 0; k < MAX_HEAPS; k++) begin
                cnt_r[k] <= '0;
              end
              we_r     <= 1'b0;
              st_r     <= ST_OK;
              freed_r  <= 1'b0;
              init_r   <= 1'b0;
              heaps_r  <= '0;
              in_use_r <= '0;
              peak_r   <= '0;
              live_r   <= '0;
              hbt_r    <= '0;
              state_r  <= S_STAT;
            end
          endcase
        end

        S_ANEXT: begin
          if (h_r == heaps_r) begin
            if (heaps_r >= HCNT_W'(MAX_HEAPS)) begin
              we_r    <= 1'b0;
              st_r    <= ST_NO_HEAP;
              state_r <= S_STAT;
            end else begin
              // No range fits: open a new heap and grant at its offset zero.
              heaps_r       <= heaps_r + 1'b1;
              cnt_r[hh]     <= RCNT_W'(1);
              we_r          <= 1'b1;
              waddr_r       <= {hh, {IDX_W{1'b0}}};
              wdata_r.start <= size_r;
              wdata_r.len   <= hs - {1'b0, size_r};
              hbt_r         <= hbt_add_hs[STAT_W] ? '1 : hbt_add_hs[STAT_W-1:0];
              grant_r       <= 1'b1;
              goff_r        <= '0;
              gheap_r       <= hh;
              state_r       <= S_STAT;
            end
          end else if (i_r == ncur) begin
            we_r <= 1'b0;
            h_r  <= h_r + 1'b1;
            i_r  <= '0;
          end else begin
            we_r    <= 1'b0;
            state_r <= S_ACHK;
          end
        end

        S_ACHK: begin
          if (!fit) begin
            we_r    <= 1'b0;
            i_r     <= i_r + 1'b1;
            state_r <= S_ANEXT;
          end else if (keep_gap && keep_rem && (ncur >= RCNT_W'(MAX_RANGES))) begin
            we_r    <= 1'b0;
            st_r    <= ST_FULL;
            state_r <= S_STAT;
          end else begin
            grant_r <= 1'b1;
            goff_r  <= al[ADDR_W-1:0];
            gheap_r <= hh;
            waddr_r <= {hh, i_r[IDX_W-1:0]};
            if (keep_gap) begin
              we_r          <= 1'b1;
              wdata_r.start <= rdata.start;
              wdata_r.len   <= pad;
              if (keep_rem) begin
                ins_r.start <= rs[ADDR_W-1:0];
                ins_r.len   <= rem;
                i_r         <= i_r + 1'b1;
                j_r         <= ncur;
                state_r     <= S_SUR;
              end else begin
                state_r <= S_STAT;
              end
            end else if (keep_rem) begin
              we_r          <= 1'b1;
              wdata_r.start <= rs[ADDR_W-1:0];
              wdata_r.len   <= rem;
              state_r       <= S_STAT;
            end else begin
              we_r    <= 1'b0;
              j_r     <= i_r;
              state_r <= S_SDR;
            end
          end
        end

        S_FNEXT: begin
          we_r <= 1'b0;
          if (i_r < ncur) begin
            state_r <= S_FCHK;
          end else begin
            state_r <= S_FDEC;
          end
        end

        S_FCHK: begin
          we_r <= 1'b0;
          if (rdata.start < foff_r) begin
            prev_r  <= rdata;
            i_r     <= i_r + 1'b1;
            state_r <= S_FNEXT;
          end else begin
            next_r    <= rdata;
            next_ok_r <= 1'b1;
            state_r   <= S_FDEC;
          end
        end

        S_FDEC: begin
          mn_r  <= next_ok_r && (off_end == {2'b00, next_r.start});
          mp_r  <= (i_r != '0) && (prev_end == {2'b00, foff_r});
          sum_r <= sum_prev[LEN_W] ? '1 : sum_prev[LEN_W-1:0];
          if (!((i_r != '0) && (prev_end == {2'b00, foff_r}))) begin
            if (next_ok_r && (off_end == {2'b00, next_r.start})) begin
              we_r          <= 1'b1;
              waddr_r       <= {hh, i_r[IDX_W-1:0]};
              wdata_r.start <= foff_r;
              wdata_r.len   <= sum_next[LEN_W] ? '1 : sum_next[LEN_W-1:0];
              freed_r       <= 1'b1;
              state_r       <= S_STAT;
            end else if (ncur >= RCNT_W'(MAX_RANGES)) begin
              we_r    <= 1'b0;
              st_r    <= ST_FULL;
              state_r <= S_STAT;
            end else begin
              we_r        <= 1'b0;
              ins_r.start <= foff_r;
              ins_r.len   <= size_r[ADDR_W-1:0] == '0 ? '0 : {1'b0, size_r};
              j_r         <= ncur;
              freed_r     <= 1'b1;
              state_r     <= S_SUR;
            end
          end else begin
            we_r    <= 1'b0;
            state_r <= S_FMRG;
          end
        end

        S_FMRG: begin
          // Merge into the lower neighbor, and absorb the upper one if it touches.
          we_r          <= 1'b1;
          waddr_r       <= {hh, IDX_W'(i_r - 1'b1)};
          wdata_r.start <= prev_r.start;
          freed_r       <= 1'b1;
          if (mn_r) begin
            wdata_r.len <= sum_both[LEN_W] ? '1 : sum_both[LEN_W-1:0];
            j_r         <= i_r;
            state_r     <= S_SDR;
          end else begin
            wdata_r.len <= sum_r;
            state_r     <= S_STAT;
          end
        end

        S_SUR: begin
          if (j_r > i_r) begin
            we_r    <= 1'b0;
            state_r <= S_SUW;
          end else begin
            we_r      <= 1'b1;
            waddr_r   <= {hh, i_r[IDX_W-1:0]};
            wdata_r   <= ins_r;
            cnt_r[hh] <= ncur + 1'b1;
            state_r   <= S_STAT;
          end
        end

        S_SUW: begin
          we_r    <= 1'b1;
          waddr_r <= {hh, j_r[IDX_W-1:0]};
          wdata_r <= rdata;
          j_r     <= j_r - 1'b1;
          state_r <= S_SUR;
        end

        S_SDR: begin
          we_r <= 1'b0;
          if ((j_r + 1'b1) < ncur) begin
            state_r <= S_SDW;
          end else begin
            cnt_r[hh] <= ncur - 1'b1;
            state_r   <= S_STAT;
          end
        end

        S_SDW: begin
          we_r    <= 1'b1;
          waddr_r <= {hh, j_r[IDX_W-1:0]};
          wdata_r <= rdata;
          j_r     <= j_r + 1'b1;
          state_r <= S_SDR;
        end

        S_STAT: begin
          we_r <= 1'b0;
          if (grant_r) begin
            in_use_r <= inuse_add[STAT_W] ? '1 : inuse_add[STAT_W-1:0];
            if (live_r != '1) begin
              live_r <= live_r + 1'b1;
            end
          end else if (freed_r) begin
            in_use_r <= (in_use_r >= {3'b000, size_r}) ? in_use_r - {3'b000, size_r} : '0;
            if (live_r != '0) begin
              live_r <= live_r - 1'b1;
            end
          end
          state_r <= S_FIN;
        end

        S_FIN: begin
          we_r <= 1'b0;
          if (out_load) begin
            peak_r      <= peak_new;
            o_status_r  <= st_r;
            o_off_r     <= grant_r ? goff_r : '0;
            o_heap_r    <= grant_r ? gheap_r : '0;
            o_avalid_r  <= grant_r;
            o_inuse_r   <= in_use_r;
            o_peak_r    <= peak_new;
            o_live_r    <= live_r;
            o_hbt_r     <= hbt_r;
            o_heaps_r   <= heaps_r;
            state_r     <= S_IDLE;
          end
        end

        default: begin
          we_r    <= 1'b0;
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
